@@ rtl/core/cau_pkg.sv @@
// Shared types and constants for the complex arithmetic unit.
package cau_pkg;

    localparam int DataW  = 16;
    localparam int FracW  = 8;
    localparam int QuotW  = 17;
    localparam int DivW   = 32;
    localparam int MagW   = 40;
    localparam int RemW   = DivW + QuotW;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic                    dz;
        logic signed [DataW-1:0] a_re;
        logic signed [DataW-1:0] a_im;
        logic signed [DataW-1:0] b_re;
        logic signed [DataW-1:0] b_im;
    } item_t;

endpackage

@@ rtl/core/cau_front.sv @@
// Front stage: accept operand beats and flag zero divisors.
module cau_front
    import cau_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_operation,
    input  logic signed [DataW-1:0] s_a_re,
    input  logic signed [DataW-1:0] s_a_im,
    input  logic signed [DataW-1:0] s_b_re,
    input  logic signed [DataW-1:0] s_b_im,
    output logic                    f_valid,
    input  logic                    f_ready,
    output item_t                   f_item
);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    assign s_ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_item  = item_reg;

    always_comb begin
        item_next.op   = op_t'(s_operation);
        item_next.dz   = (op_t'(s_operation) == OP_DIV) && (s_b_re == '0) && (s_b_im == '0);
        item_next.a_re = s_a_re;
        item_next.a_im = s_a_im;
        item_next.b_re = s_b_re;
        item_next.b_im = s_b_im;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/core/cau_queue.sv @@
// Two-entry queue between front and back.
module cau_queue
    import cau_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_item
);

    item_t      mem [0:1];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = mem[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (pop) begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg] <= wr_item;
        end
    end

endmodule

@@ rtl/core/cau_back.sv @@
// Back pipeline: products, combine, restoring divide, saturate, output register.
module cau_back
    import cau_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    b_valid,
    output logic                    b_ready,
    input  item_t                   b_item,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [DataW-1:0] m_res_re,
    output logic signed [DataW-1:0] m_res_im,
    output logic                    m_overflow,
    output logic                    m_div_zero
);

    typedef struct packed {
        logic               valid;
        op_t                op;
        logic               dz;
        logic signed [16:0] sum_re;
        logic signed [16:0] sum_im;
        logic signed [31:0] p_rr;
        logic signed [31:0] p_ii;
        logic signed [31:0] p_ri;
        logic signed [31:0] p_ir;
        logic signed [31:0] sq_r;
        logic signed [31:0] sq_i;
    } prod_t;

    typedef struct packed {
        logic                    valid;
        logic                    is_div;
        logic                    dz;
        logic signed [DataW-1:0] res_re;
        logic signed [DataW-1:0] res_im;
        logic                    ovf;
        logic                    neg_re;
        logic                    neg_im;
        logic                    big_re;
        logic                    big_im;
        logic [RemW-1:0]         rem_re;
        logic [RemW-1:0]         rem_im;
        logic [DivW-1:0]         d;
        logic [QuotW-1:0]        q_re;
        logic [QuotW-1:0]        q_im;
    } work_t;

    typedef struct packed {
        logic [DataW-1:0] val;
        logic             ovf;
    } sat_t;

    function automatic sat_t sat33(input logic signed [32:0] v);
        sat_t r;
        r.ovf = 1'b0;
        r.val = v[DataW-1:0];
        if (v > 33'sd32767) begin
            r.val = 16'h7fff;
            r.ovf = 1'b1;
        end else if (v < -33'sd32768) begin
            r.val = 16'h8000;
            r.ovf = 1'b1;
        end
        return r;
    endfunction

    function automatic logic signed [32:0] mul_scale(input logic signed [32:0] t);
        logic signed [32:0] tr;
        tr = (t < 0) ? (t + 33'sd255) : t;
        return tr >>> FracW;
    endfunction

    function automatic logic [MagW-1:0] mag_scale(input logic signed [32:0] n);
        logic [32:0] m;
        m = (n < 0) ? 33'(-n) : 33'(n);
        return {m[31:0], {FracW{1'b0}}};
    endfunction

    function automatic work_t div_step(input work_t w, input int k);
        work_t           r;
        logic [RemW-1:0] ds;
        r  = w;
        ds = RemW'(w.d) << k;
        if (w.rem_re >= ds) begin
            r.rem_re  = w.rem_re - ds;
            r.q_re[k] = 1'b1;
        end
        if (w.rem_im >= ds) begin
            r.rem_im  = w.rem_im - ds;
            r.q_im[k] = 1'b1;
        end
        return r;
    endfunction

    function automatic sat_t div_sat(input logic neg, input logic big,
                                     input logic [QuotW-1:0] q);
        sat_t r;
        r.ovf = 1'b0;
        if (!neg) begin
            if (big || q > 17'd32767) begin
                r.val = 16'h7fff;
                r.ovf = 1'b1;
            end else begin
                r.val = q[DataW-1:0];
            end
        end else begin
            if (big || q > 17'd32768) begin
                r.val = 16'h8000;
                r.ovf = 1'b1;
            end else begin
                r.val = DataW'(-q);
            end
        end
        return r;
    endfunction

    logic  en;
    prod_t sp_reg;
    prod_t sp_next;
    work_t sc_reg;
    work_t sc_next;
    work_t sb_reg;
    work_t sb_next;
    work_t sd_reg  [0:QuotW-1];
    work_t sd_next [0:QuotW-1];
    logic                    m_valid_reg;
    logic signed [DataW-1:0] re_reg;
    logic signed [DataW-1:0] im_reg;
    logic                    ovf_reg;
    logic                    dz_reg;
    sat_t                    fin_re;
    sat_t                    fin_im;

    assign en       = !m_valid_reg || m_ready;
    assign b_ready  = en;
    assign m_valid  = m_valid_reg;
    assign m_res_re = re_reg;
    assign m_res_im = im_reg;
    assign m_overflow = ovf_reg;
    assign m_div_zero = dz_reg;

    always_comb begin
        sp_next.valid = b_valid;
        sp_next.op    = b_item.op;
        sp_next.dz    = b_item.dz;
        if (b_item.op == OP_SUB) begin
            sp_next.sum_re = 17'(b_item.a_re) - 17'(b_item.b_re);
            sp_next.sum_im = 17'(b_item.a_im) - 17'(b_item.b_im);
        end else begin
            sp_next.sum_re = 17'(b_item.a_re) + 17'(b_item.b_re);
            sp_next.sum_im = 17'(b_item.a_im) + 17'(b_item.b_im);
        end
        sp_next.p_rr = b_item.a_re * b_item.b_re;
        sp_next.p_ii = b_item.a_im * b_item.b_im;
        sp_next.p_ri = b_item.a_re * b_item.b_im;
        sp_next.p_ir = b_item.a_im * b_item.b_re;
        sp_next.sq_r = b_item.b_re * b_item.b_re;
        sp_next.sq_i = b_item.b_im * b_item.b_im;
    end

    always_comb begin
        logic signed [32:0] nr;
        logic signed [32:0] ni;
        sat_t               sr;
        sat_t               si;
        sc_next        = '0;
        sc_next.valid  = sp_reg.valid;
        sc_next.dz     = sp_reg.dz;
        nr = '0;
        ni = '0;
        sr = '0;
        si = '0;
        unique case (sp_reg.op)
            OP_ADD, OP_SUB: begin
                sr = sat33(33'(sp_reg.sum_re));
                si = sat33(33'(sp_reg.sum_im));
            end
            OP_MUL: begin
                sr = sat33(mul_scale(33'(sp_reg.p_rr) - 33'(sp_reg.p_ii)));
                si = sat33(mul_scale(33'(sp_reg.p_ri) + 33'(sp_reg.p_ir)));
            end
            OP_DIV: begin
                sc_next.is_div = !sp_reg.dz;
                nr = 33'(sp_reg.p_rr) + 33'(sp_reg.p_ii);
                ni = 33'(sp_reg.p_ir) - 33'(sp_reg.p_ri);
            end
            default: begin
            end
        endcase
        sc_next.res_re = sr.val;
        sc_next.res_im = si.val;
        sc_next.ovf    = sr.ovf || si.ovf;
        sc_next.neg_re = nr < 0;
        sc_next.neg_im = ni < 0;
        sc_next.rem_re = RemW'(mag_scale(nr));
        sc_next.rem_im = RemW'(mag_scale(ni));
        sc_next.d      = DivW'(sp_reg.sq_r) + DivW'(sp_reg.sq_i);
    end

    always_comb begin
        sb_next        = sc_reg;
        sb_next.big_re = sc_reg.rem_re >= (RemW'(sc_reg.d) << QuotW);
        sb_next.big_im = sc_reg.rem_im >= (RemW'(sc_reg.d) << QuotW);
        if (sb_next.big_re) begin
            sb_next.rem_re = '0;
        end
        if (sb_next.big_im) begin
            sb_next.rem_im = '0;
        end
    end

    always_comb begin
        sd_next[0] = div_step(sb_reg, QuotW - 1);
        for (int i = 1; i < QuotW; i++) begin
            sd_next[i] = div_step(sd_reg[i-1], QuotW - 1 - i);
        end
    end

    always_comb begin
        fin_re = div_sat(sd_reg[QuotW-1].neg_re, sd_reg[QuotW-1].big_re,
                         sd_reg[QuotW-1].q_re);
        fin_im = div_sat(sd_reg[QuotW-1].neg_im, sd_reg[QuotW-1].big_im,
                         sd_reg[QuotW-1].q_im);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= '0;
            sc_reg      <= '0;
            sb_reg      <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < QuotW; i++) begin
                sd_reg[i] <= '0;
            end
        end else if (en) begin
            sp_reg      <= sp_next;
            sc_reg      <= sc_next;
            sb_reg      <= sb_next;
            m_valid_reg <= sd_reg[QuotW-1].valid;
            for (int i = 0; i < QuotW; i++) begin
                sd_reg[i] <= sd_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (sd_reg[QuotW-1].is_div) begin
                re_reg  <= fin_re.val;
                im_reg  <= fin_im.val;
                ovf_reg <= fin_re.ovf || fin_im.ovf;
            end else begin
                re_reg  <= sd_reg[QuotW-1].res_re;
                im_reg  <= sd_reg[QuotW-1].res_im;
                ovf_reg <= sd_reg[QuotW-1].ovf;
            end
            dz_reg <= sd_reg[QuotW-1].dz;
        end
    end

endmodule

@@ rtl/core/complex_arith_unit.sv @@
// Top level of the complex arithmetic unit.
//
//  channel  direction  ports                                  handshake
//  s_       in         operation, a_re, a_im, b_re, b_im      s_valid / s_ready
//  m_       out        res_re, res_im, overflow, div_zero     m_valid / m_ready
//
// One beat in and one beat out per cycle when both sides flow.
// Beats pass in order through the front register, queue, product, combine,
// range check, 17 divide steps (one quotient bit each), output register.
// Synchronous active-low reset empties all stages.
// A stall on m_ready holds the back pipeline; the queue and front keep
// taking beats until they fill.
module complex_arith_unit
    import cau_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_operation,
    input  logic signed [DataW-1:0] s_a_re,
    input  logic signed [DataW-1:0] s_a_im,
    input  logic signed [DataW-1:0] s_b_re,
    input  logic signed [DataW-1:0] s_b_im,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [DataW-1:0] m_res_re,
    output logic signed [DataW-1:0] m_res_im,
    output logic                    m_overflow,
    output logic                    m_div_zero
);

    logic  f_valid;
    logic  f_ready;
    item_t f_item;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    cau_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_a_re      (s_a_re),
        .s_a_im      (s_a_im),
        .s_b_re      (s_b_re),
        .s_b_im      (s_b_im),
        .f_valid     (f_valid),
        .f_ready     (f_ready),
        .f_item      (f_item)
    );

    cau_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    cau_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .b_valid    (q_valid),
        .b_ready    (q_ready),
        .b_item     (q_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res_re   (m_res_re),
        .m_res_im   (m_res_im),
        .m_overflow (m_overflow),
        .m_div_zero (m_div_zero)
    );

endmodule
